/* design/dpq_pkg.sv */
// ============================================================================
// dpq_pkg
// Shared types and constants for the double-ended priority queue core:
// operation codes, the value width and the command word that every cell
// in the sorted chain receives.
// ============================================================================
package dpq_pkg;

    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int COUNT_OUT_W   = 7;
    localparam int DEFAULT_DEPTH = 64;

    // Operation codes carried on i_operation
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL_MAX = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL_MIN = 2'd2;

    // Command broadcast to every cell of the chain in the apply cycle
    typedef struct packed {
        logic                      ins;    // place value into the sorted row
        logic                      shl;    // shift the row down (drop minimum)
        logic signed [VALUE_W-1:0] value;  // value being inserted
    } t_cell_cmd;

endpackage

/* design/dpq_cell.sv */
// ============================================================================
// dpq_cell
// One slot of the sorted row. Holds one value, flags whether it is greater
// than the value being inserted, and on a command takes its own value, its
// left neighbor's value, its right neighbor's value or the new value.
// ============================================================================
module dpq_cell
    import dpq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_cmd                 i_cmd,
    input  logic                      i_occ,        // slot holds a live entry
    input  logic                      i_left_gt,    // left neighbor exceeds new value
    input  logic signed [VALUE_W-1:0] i_left_val,
    input  logic signed [VALUE_W-1:0] i_right_val,
    output logic                      o_gt,
    output logic signed [VALUE_W-1:0] o_val
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    // Compare the stored entry against the value being inserted
    assign o_gt  = i_occ && (r_val > i_cmd.value);
    assign o_val = r_val;

    // Pick the next slot content: shift right, take new value, shift left or hold
    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (!i_occ || o_gt) begin
                n_val = i_cmd.value;
            end
        end else if (i_cmd.shl) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* design/double_ended_priority_queue_core.sv */
// ============================================================================
// double_ended_priority_queue_core
// Double-ended priority queue of signed 32-bit values kept in a sorted row
// of cells; reports maximum, minimum, count, empty and overflow per command.
// ============================================================================
// Usage: a command (insert, delete maximum, delete minimum) is taken when
// start is high and busy is low. After a command is taken, busy stays high
// through the apply and report states: in apply every cell of the sorted
// row updates at once from its neighbors (insert shifts the larger entries
// up one slot, delete minimum shifts the row down, delete maximum only
// lowers the count); in report the maximum is picked from the top occupied
// cell and the report is registered. The report shows on the o_ ports for
// exactly one cycle with o_valid high, starting at the edge where busy
// drops, and the receiver cannot stall it; a new command may be issued in
// the same cycle that the report is shown, so a command is not taken while
// another is still in flight. Deletes on an empty queue are ignored,
// inserts into a full queue are dropped with o_overflow set, both extremes
// read 0 when empty, and operation code 3 only reports the state.
// o_entry_count is the count modulo 128.
// ============================================================================
module double_ended_priority_queue_core
    import dpq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [OP_W-1:0]               i_operation,
    input  logic signed [VALUE_W-1:0]     i_value,
    output logic                          o_valid,
    output logic signed [VALUE_W-1:0]     o_max_value,
    output logic signed [VALUE_W-1:0]     o_min_value,
    output logic [COUNT_OUT_W-1:0]        o_entry_count,
    output logic                          o_is_empty,
    output logic                          o_overflow
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_REPORT
    } t_state;

    t_state                    r_state;
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_arg;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_ovf;
    logic                      n_ovf;

    t_cell_cmd                 cmd;
    logic                      full;
    logic [DEPTH:0]            occ;
    logic [DEPTH-1:0]          gt;
    logic signed [VALUE_W-1:0] cell_val [DEPTH];
    logic signed [VALUE_W-1:0] top_val;

    assign busy = (r_state != S_IDLE);
    assign full = (r_count == CW'(DEPTH));

    // Mark occupied slots; one spare bit above the row stays clear
    always_comb begin
        occ = '0;
        for (int i = 0; i < DEPTH; i++) begin
            occ[i] = (CW'(i) < r_count);
        end
    end

    // Build the row command for the apply cycle
    always_comb begin
        cmd.ins   = (r_state == S_APPLY) && (r_op == OP_INSERT) && !full;
        cmd.shl   = (r_state == S_APPLY) && (r_op == OP_DEL_MIN) && (r_count != '0);
        cmd.value = r_arg;
    end

    // Sorted chain of cells, ascending from slot 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_occ       (occ[g]),
            .i_left_gt   ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g - 1]),
            .i_left_val  (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right_val (cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_gt        (gt[g]),
            .o_val       (cell_val[g])
        );
    end

    // Select the top occupied slot as the maximum
    always_comb begin
        top_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (occ[i] && !occ[i+1]) begin
                top_val = top_val | cell_val[i];
            end
        end
    end

    // Advance the count and flag dropped inserts
    always_comb begin
        n_count = r_count;
        n_ovf   = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEL_MAX, OP_DEL_MIN: begin
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Sequence one transaction: capture, apply to the row, report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_operation;
                        r_arg   <= i_value;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    o_valid       <= 1'b1;
                    o_max_value   <= top_val;
                    o_min_value   <= occ[0] ? cell_val[0] : '0;
                    o_entry_count <= COUNT_OUT_W'(r_count);
                    o_is_empty    <= (r_count == '0);
                    o_overflow    <= r_ovf;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Count never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // A report follows only a report cycle
    a_valid_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_REPORT))
        else $error("report strobe without a transaction");

    // Overflow is flagged only with a full queue
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> full)
        else $error("overflow reported while queue not full");

    // Empty queue reports zero extremes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_max_value == '0 && o_min_value == '0))
        else $error("empty queue reported nonzero extremes");

endmodule
